/* rtl/ehpc_pkg.sv */
// shared constants and types of the earliest-hit-per-channel filter
`default_nettype none

package ehpc_pkg;

    localparam int LAYERS          = 32;
    localparam int CELLS_PER_LAYER = 512;
    localparam int MAX_HITS        = 1024;

    localparam int LAYER_W = 5;
    localparam int CELL_W  = 9;
    localparam int IDX_W   = 10;
    localparam int TIME_W  = 32;

    localparam int WIRE_COUNT = LAYERS * CELLS_PER_LAYER;
    localparam int ADDR_W     = $clog2(WIRE_COUNT);

    // generation tag kept with every wire entry; tag zero never matches
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [EPOCH_W-1:0]       epoch;
        logic [IDX_W-1:0]         idx;
        logic signed [TIME_W-1:0] drift;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* rtl/ehpc_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module ehpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/earliest_hit_per_channel_filter_core.sv */
// earliest hit per wire: table update and query through one ram
//
// Input channel s_*: one request per item, s_tuser carries the mode (clear,
// load, query, nop), s_tdata the wire address, hit index and drift time. Output
// channel m_*: exactly one result per request, in request order.
// A request is read from the table at acceptance and held in the read stage;
// it is modified and written back when it leaves that stage, and its result
// is registered on m_* at the same edge. Back-to-back requests to the same wire
// are served from a one-entry forward register, so one request per cycle
// is sustained as long as m_tready stays high and no sweep runs; the single
// table port pair (one read, one write per cycle) sets that figure.
// A clear does not touch the table: it advances an 8-bit generation tag, and
// an entry counts only if its tag matches. Once in 255 clears the tag wraps
// and the table is swept, one entry per cycle; s_tready stays low while the
// wrapping clear waits in the read stage and until all 16384 entries are swept.
// The same sweep runs after reset before the first request is taken.
// When m_tready is low the result holds on m_* and the next request waits in
// the read stage; s_tready drops until the output register frees up.
`default_nettype none

module earliest_hit_per_channel_filter_core
    import ehpc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // layer[4:0], cell_req[13:5], hit_index[23:14], drift_time[55:24]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  wire logic [1:0]           s_tuser,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // winner_index[9:0], winner_time[41:10], zero[47:42]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // is_winner[0], entry_valid[1]
    output logic [1:0]                m_tuser
);

    // input field split
    logic [LAYER_W-1:0]       in_layer;
    logic [CELL_W-1:0]        in_cell;
    logic [IDX_W-1:0]         in_idx;
    logic signed [TIME_W-1:0] in_time;
    logic                     in_range;
    logic [ADDR_W-1:0]        in_addr;
    logic                     s_accept;

    assign in_layer = s_tdata[LAYER_W-1:0];
    assign in_cell  = s_tdata[LAYER_W+CELL_W-1:LAYER_W];
    assign in_idx   = s_tdata[LAYER_W+CELL_W+IDX_W-1:LAYER_W+CELL_W];
    assign in_time  = s_tdata[LAYER_W+CELL_W+IDX_W+TIME_W-1:LAYER_W+CELL_W+IDX_W];

    assign in_range = (int'(in_layer) < LAYERS) && (int'(in_cell) < CELLS_PER_LAYER);
    assign in_addr  = in_range ?
        ADDR_W'(ADDR_W'(in_layer) * ADDR_W'(CELLS_PER_LAYER) + ADDR_W'(in_cell)) : '0;

    // read stage
    logic                     s1_valid_reg;
    mode_t                    s1_mode_reg;
    logic [ADDR_W-1:0]        s1_addr_reg;
    logic                     s1_range_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic signed [TIME_W-1:0] s1_time_reg;

    // last write, for a request whose read raced it
    logic                     fwd_valid_reg;
    logic [ADDR_W-1:0]        fwd_addr_reg;
    entry_t                   fwd_data_reg;

    logic [EPOCH_W-1:0]       epoch_reg;
    logic                     sweep_reg;
    logic [ADDR_W-1:0]        sweep_cnt_reg;

    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [1:0]               m_tuser_reg;

    // table
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic [ENTRY_W-1:0]       ram_rdata;

    logic                     advance;
    logic                     wrap_hold;
    entry_t                   cur;
    logic                     occupied;
    logic                     idx_ok;
    logic                     take;
    entry_t                   entry_next;
    logic                     valid_next;
    logic                     first_next;
    logic [M_TDATA_W-1:0]     m_tdata_next;
    logic [1:0]               m_tuser_next;

    assign advance   = !m_tvalid_reg || m_tready;
    assign wrap_hold = s1_valid_reg && (s1_mode_reg == MODE_CLEAR) && (epoch_reg == EPOCH_LAST);
    assign s_tready  = advance && !sweep_reg && !wrap_hold;
    assign s_accept  = s_tvalid && s_tready;

    assign cur      = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                       : entry_t'(ram_rdata);
    assign occupied = s1_range_reg && (cur.epoch == epoch_reg);
    assign idx_ok   = int'(s1_idx_reg) < MAX_HITS;
    assign take     = (s1_mode_reg == MODE_LOAD) && s1_range_reg && idx_ok &&
                      (!occupied || (s1_time_reg < cur.drift));

    always_comb begin
        entry_next = cur;
        if (take) begin
            entry_next.epoch = epoch_reg;
            entry_next.idx   = s1_idx_reg;
            entry_next.drift = s1_time_reg;
        end

        valid_next = 1'b0;
        first_next = 1'b0;
        unique case (s1_mode_reg)
            MODE_LOAD: begin
                valid_next = occupied || take;
            end
            MODE_QUERY: begin
                valid_next = occupied;
                first_next = occupied && idx_ok && (cur.idx == s1_idx_reg);
            end
            default: begin
                valid_next = 1'b0;
            end
        endcase

        m_tuser_next = {valid_next, first_next};
        m_tdata_next = '0;
        if (valid_next) begin
            m_tdata_next = M_TDATA_W'({entry_next.drift, entry_next.idx});
        end
    end

    assign ram_we    = sweep_reg || (advance && s1_valid_reg && take);
    assign ram_waddr = sweep_reg ? sweep_cnt_reg : s1_addr_reg;
    assign ram_wdata = sweep_reg ? '0 : ENTRY_W'(entry_next);

    ehpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WIRE_COUNT)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            epoch_reg     <= EPOCH_FIRST;
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end else begin
            if (sweep_reg) begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == ADDR_W'(WIRE_COUNT - 1)) begin
                    sweep_reg <= 1'b0;
                end
            end

            if (advance) begin
                s1_valid_reg <= s_accept;
                m_tvalid_reg <= s1_valid_reg;
                if (s1_valid_reg) begin
                    m_tdata_reg <= m_tdata_next;
                    m_tuser_reg <= m_tuser_next;
                    if (take) begin
                        fwd_valid_reg <= 1'b1;
                        fwd_addr_reg  <= s1_addr_reg;
                        fwd_data_reg  <= entry_next;
                    end
                    if (s1_mode_reg == MODE_CLEAR) begin
                        if (epoch_reg == EPOCH_LAST) begin
                            // tag space used up: wipe all tags back to zero
                            epoch_reg     <= EPOCH_FIRST;
                            sweep_reg     <= 1'b1;
                            sweep_cnt_reg <= '0;
                            fwd_valid_reg <= 1'b0;
                        end else begin
                            epoch_reg <= epoch_reg + 1'b1;
                        end
                    end
                end
            end

            if (s_accept) begin
                s1_mode_reg  <= mode_t'(s_tuser);
                s1_addr_reg  <= in_addr;
                s1_range_reg <= in_range;
                s1_idx_reg   <= in_idx;
                s1_time_reg  <= in_time;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // no request enters while the table is being swept
    assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_reg |-> !s_accept)
        else $error("request accepted during table sweep");

    // the live tag never takes the value that the sweep writes
    assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != '0)
        else $error("generation tag reached zero");

    // a hit can only be the winner of an occupied wire
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[0] |-> m_tuser_reg[1])
        else $error("winner flag without entry_valid");

    // an empty wire reports zero index and time
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tuser_reg[1] |-> (m_tdata_reg == '0))
        else $error("winner fields nonzero on empty wire");

    // a clear that wraps the tag starts a sweep on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && wrap_hold |=> sweep_reg)
        else $error("tag wrap without table sweep");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the earliest-hit-per-channel filter core
`default_nettype none

module testbench
    import ehpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_REQUESTS = 400;
    localparam int WRAP_ROUNDS = 260;
    localparam int POOL_SIZE = 8;

    typedef struct {
        bit                       is_winner;
        bit                       entry_valid;
        bit [IDX_W-1:0]           winner_index;
        bit signed [TIME_W-1:0]   winner_time;
    } wire_report_t;

    // keeps its own copy of the wire table and the reports still owed by the core
    class wire_winner_board;
        bit                     occupied [WIRE_COUNT];
        bit signed [TIME_W-1:0] best_time [WIRE_COUNT];
        bit [IDX_W-1:0]         min_index [WIRE_COUNT];
        wire_report_t           due_reports [$];
        int                     errors;

        function void note_request(mode_t mode, bit [LAYER_W-1:0] layer,
                                   bit [CELL_W-1:0] cell_no, bit [IDX_W-1:0] idx,
                                   bit signed [TIME_W-1:0] drift);
            bit [ADDR_W-1:0] addr;
            wire_report_t    rep;
            addr = {layer, cell_no};
            rep = '{default: 0};
            case (mode)
                MODE_CLEAR: begin
                    foreach (occupied[i]) occupied[i] = 1'b0;
                end
                MODE_LOAD: begin
                    // strict compare: on equal times the earlier load keeps the wire
                    if (!occupied[addr] || drift < best_time[addr]) begin
                        occupied[addr] = 1'b1;
                        best_time[addr] = drift;
                        min_index[addr] = idx;
                    end
                end
                MODE_QUERY: begin
                    rep.is_winner = occupied[addr] && min_index[addr] == idx;
                end
                default: ;
            endcase
            if ((mode == MODE_LOAD || mode == MODE_QUERY) && occupied[addr]) begin
                rep.entry_valid = 1'b1;
                rep.winner_index = min_index[addr];
                rep.winner_time = best_time[addr];
            end
            due_reports.push_back(rep);
        endfunction

        function void check_report(logic [M_TDATA_W-1:0] tdata, logic [1:0] tuser);
            wire_report_t rep;
            if (due_reports.size() == 0) begin
                $error("result with no request pending: tdata %h tuser %b", tdata, tuser);
                errors++;
                return;
            end
            rep = due_reports.pop_front();
            if (tuser[0] !== rep.is_winner) begin
                $error("is_winner: expected %0d, got %0d", rep.is_winner, tuser[0]);
                errors++;
            end
            if (tuser[1] !== rep.entry_valid) begin
                $error("entry_valid: expected %0d, got %0d", rep.entry_valid, tuser[1]);
                errors++;
            end
            if (tdata[9:0] !== rep.winner_index) begin
                $error("winner_index: expected %0d, got %0d", rep.winner_index, tdata[9:0]);
                errors++;
            end
            if (tdata[41:10] !== rep.winner_time) begin
                $error("winner_time: expected %0d, got %0d",
                       rep.winner_time, $signed(tdata[41:10]));
                errors++;
            end
            if (tdata[47:42] !== 6'd0) begin
                $error("tdata padding: expected 0, got %h", tdata[47:42]);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [1:0]             m_tuser;

    logic                   no_idle = 1'b0;
    int                     cycle_count = 0;
    wire_winner_board       board = new();

    bit [LAYER_W-1:0]       pool_layer [POOL_SIZE];
    bit [CELL_W-1:0]        pool_cell [POOL_SIZE];

    earliest_hit_per_channel_filter_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("earliest_hit_per_channel_filter_core regression: fail");
            $finish;
        end
    end

    // stretches where neither side idles
    initial begin
        forever begin
            repeat ($urandom_range(50, 300)) @(posedge aclk);
            no_idle <= ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            board.check_report(m_tdata, m_tuser);
        end
    end

    task automatic send_request(mode_t mode, bit [LAYER_W-1:0] layer,
                                bit [CELL_W-1:0] cell_no, bit [IDX_W-1:0] idx,
                                bit signed [TIME_W-1:0] drift);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {drift, idx, cell_no, layer};
        s_tuser <= mode;
        do @(posedge aclk); while (s_tready !== 1'b1);
        board.note_request(mode, layer, cell_no, idx, drift);
    endtask

    task automatic wait_all_reported();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.due_reports.size() != 0);
    endtask

    function automatic bit signed [TIME_W-1:0] pick_drift();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 40) - 20;
        if (r < 70) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 0;
                default: return -1;
            endcase
        end
        return $urandom();
    endfunction

    initial begin : stimulus
        int k;
        int r;
        int p;
        mode_t mode;
        bit [LAYER_W-1:0] layer;
        bit [CELL_W-1:0] cell_no;
        bit [IDX_W-1:0] idx;
        bit [ADDR_W-1:0] addr;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty wire, equal/later/earlier times, field extremes
        send_request(MODE_QUERY, 5'd0, 9'd0, 10'd0, 0);
        send_request(MODE_LOAD, 5'd0, 9'd0, 10'd5, 100);
        send_request(MODE_LOAD, 5'd0, 9'd0, 10'd6, 100);
        send_request(MODE_LOAD, 5'd0, 9'd0, 10'd7, 200);
        send_request(MODE_LOAD, 5'd0, 9'd0, 10'd8, -1);
        send_request(MODE_QUERY, 5'd0, 9'd0, 10'd8, 0);
        send_request(MODE_QUERY, 5'd0, 9'd0, 10'd5, 0);
        send_request(MODE_LOAD, 5'd31, 9'd511, 10'd1023, 32'sh7FFF_FFFF);
        send_request(MODE_LOAD, 5'd31, 9'd511, 10'd0, 32'sh8000_0000);
        send_request(MODE_QUERY, 5'd31, 9'd511, 10'd0, 0);
        send_request(MODE_QUERY, 5'd31, 9'd511, 10'd1023, -1);
        send_request(MODE_NOP, 5'd31, 9'd511, 10'd1023, -1);
        send_request(MODE_LOAD, 5'd31, 9'd0, 10'd1023, 32'sh7FFF_FFFF);
        send_request(MODE_LOAD, 5'd0, 9'd511, 10'd512, 32'sh8000_0000);
        send_request(MODE_LOAD, 5'd0, 9'd511, 10'd513, 32'sh8000_0000);
        send_request(MODE_QUERY, 5'd0, 9'd511, 10'd512, 0);
        send_request(MODE_CLEAR, 5'd31, 9'd511, 10'd1023, -1);
        send_request(MODE_QUERY, 5'd0, 9'd0, 10'd8, 0);
        send_request(MODE_QUERY, 5'd31, 9'd511, 10'd0, 0);
        send_request(MODE_LOAD, 5'd0, 9'd0, 10'd1, 32'sh7FFF_FFFF);
        send_request(MODE_LOAD, 5'd0, 9'd0, 10'd2, 4);
        send_request(MODE_QUERY, 5'd0, 9'd0, 10'd2, 0);
        wait_all_reported();

        foreach (pool_layer[i]) begin
            pool_layer[i] = LAYER_W'($urandom());
            pool_cell[i] = CELL_W'($urandom());
        end

        // random: a few hot wires so loads collide and queries find winners
        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k % 100 == 0) begin
                p = $urandom_range(0, POOL_SIZE - 1);
                pool_layer[p] = LAYER_W'($urandom());
                pool_cell[p] = CELL_W'($urandom());
            end
            if (k == 200) wait_all_reported();
            r = $urandom_range(0, 99);
            if (r < 3) mode = MODE_CLEAR;
            else if (r < 10) mode = MODE_NOP;
            else if (r < 55) mode = MODE_LOAD;
            else mode = MODE_QUERY;
            if ($urandom_range(0, 99) < 85) begin
                p = $urandom_range(0, POOL_SIZE - 1);
                layer = pool_layer[p];
                cell_no = pool_cell[p];
            end else begin
                layer = LAYER_W'($urandom());
                cell_no = CELL_W'($urandom());
            end
            addr = {layer, cell_no};
            idx = IDX_W'($urandom());
            if (mode == MODE_QUERY && board.occupied[addr] && $urandom_range(0, 1))
                idx = board.min_index[addr];
            send_request(mode, layer, cell_no, idx, pick_drift());
        end

        // enough clears to wrap the generation tag and force a table sweep
        for (k = 0; k < WRAP_ROUNDS; k++) begin
            send_request(MODE_CLEAR, LAYER_W'($urandom()), CELL_W'($urandom()),
                         IDX_W'($urandom()), pick_drift());
            p = $urandom_range(0, POOL_SIZE - 1);
            addr = {pool_layer[p], pool_cell[p]};
            send_request(MODE_LOAD, pool_layer[p], pool_cell[p], IDX_W'($urandom()),
                         pick_drift());
            send_request(MODE_QUERY, pool_layer[p], pool_cell[p], board.min_index[addr], 0);
            if (k % 8 == 0) begin
                p = (p + 1) % POOL_SIZE;
                send_request(MODE_QUERY, pool_layer[p], pool_cell[p], IDX_W'($urandom()), 0);
            end
        end

        wait_all_reported();
        repeat (8) @(posedge aclk);
        if (board.errors == 0 && board.due_reports.size() == 0)
            $display("earliest_hit_per_channel_filter_core regression: pass");
        else
            $display("earliest_hit_per_channel_filter_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* earliest_hit_per_channel_filter_core.f */
rtl/ehpc_pkg.sv
rtl/ehpc_ram.sv
rtl/earliest_hit_per_channel_filter_core.sv
tb/testbench.sv
